>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is active
`define LPATO_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lpato assertion failed");

// clocked assertion that also holds during reset
`define LPATO_ASSERT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lpato assertion failed");

`endif

>>> rtl/lpato_pkg.sv
// package with constants, types and the arctangent table of the point time block
package lpato_pkg;

    localparam int RINGS        = 64;
    localparam int ANGLE_BITS   = 16;
    localparam int RING_AW      = (RINGS > 1) ? $clog2(RINGS) : 1;
    localparam int RING_W       = 8;
    localparam int POS_W        = 24;
    localparam int PERIOD_W     = 30;
    localparam int TIME_W       = 31;
    localparam int STATUS_W     = 2;
    localparam int ACC_W        = 32;
    localparam int SCALE_SH     = 30;
    localparam int CW           = 58;
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int PROD_W       = ANGLE_BITS + PERIOD_W;
    localparam int RAM_W        = ANGLE_BITS + TIME_W;

    localparam logic [STEP_W-1:0]   LAST_STEP    = STEP_W'(CORDIC_STEPS - 1);
    localparam logic [ACC_W-1:0]    HALF_TURN    = ACC_W'(1) << (ACC_W - 1);
    localparam logic [ACC_W-1:0]    ROUND_HALF   = ACC_W'(1) << (ACC_W - 1 - ANGLE_BITS);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(100000000);

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FIRST = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AZIM,
        S_MUL,
        S_FIX,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                  done;
        logic [ANGLE_BITS-1:0] angle;
    } cordic_res_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [ACC_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [ACC_W-1:0] v;
        begin
            case (i)
                5'd0:    v = 32'h20000000;
                5'd1:    v = 32'h12E4051E;
                5'd2:    v = 32'h09FB385B;
                5'd3:    v = 32'h051111D4;
                5'd4:    v = 32'h028B0D43;
                5'd5:    v = 32'h0145D7E1;
                5'd6:    v = 32'h00A2F61E;
                5'd7:    v = 32'h00517C55;
                5'd8:    v = 32'h0028BE53;
                5'd9:    v = 32'h00145F2F;
                5'd10:   v = 32'h000A2F98;
                5'd11:   v = 32'h000517CC;
                5'd12:   v = 32'h00028BE6;
                5'd13:   v = 32'h000145F3;
                5'd14:   v = 32'h0000A2FA;
                5'd15:   v = 32'h0000517D;
                5'd16:   v = 32'h000028BE;
                5'd17:   v = 32'h0000145F;
                5'd18:   v = 32'h00000A30;
                5'd19:   v = 32'h00000518;
                5'd20:   v = 32'h0000028C;
                5'd21:   v = 32'h00000146;
                5'd22:   v = 32'h000000A3;
                5'd23:   v = 32'h00000051;
                5'd24:   v = 32'h00000029;
                5'd25:   v = 32'h00000014;
                5'd26:   v = 32'h0000000A;
                5'd27:   v = 32'h00000005;
                5'd28:   v = 32'h00000003;
                5'd29:   v = 32'h00000001;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

>>> rtl/lpato_if.sv
// valid/ready interfaces for points, results and the period register
interface lpato_point_if;
    import lpato_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    first_of_cloud;
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic [RING_W-1:0]       ring_index;

    modport source (output valid, first_of_cloud, x_pos, y_pos, ring_index, input ready);
    modport sink   (input valid, first_of_cloud, x_pos, y_pos, ring_index, output ready);
endinterface

interface lpato_result_if;
    import lpato_pkg::*;
    logic                valid;
    logic                ready;
    logic [TIME_W-1:0]   offset_time_ns;
    logic [STATUS_W-1:0] point_status;

    modport source (output valid, offset_time_ns, point_status, input ready);
    modport sink   (input valid, offset_time_ns, point_status, output ready);
endinterface

interface lpato_cfg_if;
    import lpato_pkg::*;
    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] scan_period_ns;

    modport source (output valid, scan_period_ns, input ready);
    modport sink   (input valid, scan_period_ns, output ready);
endinterface

>>> rtl/lpato_ram.sv
// generic single write port ram with registered read
module lpato_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lpato_cordic.sv
// iterative cordic atan2 unit, one vectoring step per cycle
module lpato_cordic import lpato_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [POS_W-1:0] x_in,
    input  logic signed [POS_W-1:0] y_in,
    output cordic_res_t             res
);

    logic signed [CW-1:0] cx_reg;
    logic signed [CW-1:0] cy_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 zero_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic signed [CW-1:0] x_sc;
    logic signed [CW-1:0] y_sc;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic [ACC_W-1:0]     acc_rnd;
    logic                 x_neg;

    assign x_neg   = x_in[POS_W-1];
    assign x_sc    = {{(CW - POS_W - SCALE_SH){x_in[POS_W-1]}}, x_in, {SCALE_SH{1'b0}}};
    assign y_sc    = {{(CW - POS_W - SCALE_SH){y_in[POS_W-1]}}, y_in, {SCALE_SH{1'b0}}};
    assign dx      = cy_reg >>> step_reg;
    assign dy      = cx_reg >>> step_reg;
    assign acc_rnd = acc_reg + ROUND_HALF;

    assign res.done  = done_reg;
    assign res.angle = zero_reg ? '0 : acc_rnd[ACC_W-1 -: ANGLE_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cx_reg   <= x_neg ? -x_sc : x_sc;
            cy_reg   <= x_neg ? -y_sc : y_sc;
            acc_reg  <= x_neg ? HALF_TURN : '0;
            zero_reg <= (x_in == '0) && (y_in == '0);
        end
        else if (busy_reg)
        begin
            if (cy_reg > 0)
            begin
                cx_reg  <= cx_reg + dx;
                cy_reg  <= cy_reg - dy;
                acc_reg <= acc_reg + atan_turn(step_reg);
            end
            else
            begin
                cx_reg  <= cx_reg - dx;
                cy_reg  <= cy_reg + dy;
                acc_reg <= acc_reg - atan_turn(step_reg);
            end
        end
    end

endmodule

>>> rtl/lidar_point_azimuth_time_offset.sv
// top level: point time offset inside a lidar sweep from the point azimuth
//
// point channel takes x_pos, y_pos, ring_index and first_of_cloud; result channel
// returns offset_time_ns and point_status; cfg channel writes scan_period_ns and
// is always ready, to be written only while the block is idle.
// one point is processed at a time; point.ready is high only when idle.
// a point on a valid ring passes from acceptance to result valid through the
// iterative cordic unit, one step per cycle, then the angle capture, the
// period multiply, the wrap correction and the output load.
// a point whose ring is out of range goes straight to the output load with
// status 2, and the block is ready again once that result is loaded.
// sustained point rate is set by the cordic iteration and the output load.
// per-ring first azimuth and last time live in one ram; seen bits are flops.
// reset clears the seen bits, sets the period to 100000000 ns and empties the
// output register. a stalled receiver holds the result in the output register;
// the next point is accepted meanwhile, and its result waits until that
// register is free.
module lidar_point_azimuth_time_offset import lpato_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    lpato_point_if.sink    point,
    lpato_result_if.source result,
    lpato_cfg_if.sink      cfg
);

    state_t state_reg;
    state_t state_next;

    logic [RINGS-1:0]    seen_reg;
    logic [RINGS-1:0]    seen_next;
    logic [PERIOD_W-1:0] period_reg;
    logic                out_valid_reg;
    logic [TIME_W-1:0]   out_time_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [RING_AW-1:0]    ring_reg;
    logic                  seen_hit_reg;
    logic [ANGLE_BITS-1:0] angle_reg;
    logic [ANGLE_BITS-1:0] diff_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [TIME_W-1:0]     res_time_reg;
    logic [STATUS_W-1:0]   res_status_reg;

    logic                  accept;
    logic                  in_range;
    logic                  cordic_start;
    logic                  ram_we;
    logic                  out_load;
    logic [RING_AW-1:0]    in_ring;
    logic [RAM_W-1:0]      ram_rdata;
    logic [RAM_W-1:0]      ram_wdata;
    logic [ANGLE_BITS-1:0] first_angle;
    logic [TIME_W-1:0]     last_time;
    logic [TIME_W-1:0]     t_ext;
    logic [TIME_W-1:0]     t_fix;
    cordic_res_t           cres;

    assign in_ring     = point.ring_index[RING_AW-1:0];
    assign in_range    = {1'b0, point.ring_index} < (RING_W + 1)'(RINGS);
    assign first_angle = ram_rdata[RAM_W-1 -: ANGLE_BITS];
    assign last_time   = ram_rdata[TIME_W-1:0];
    assign t_ext       = {1'b0, prod_reg[ANGLE_BITS +: PERIOD_W]};
    assign t_fix       = (t_ext < last_time) ? t_ext + TIME_W'(period_reg) : t_ext;
    assign ram_wdata   = seen_hit_reg ? {first_angle, t_fix} : {angle_reg, {TIME_W{1'b0}}};

    assign cfg.ready             = 1'b1;
    assign result.valid          = out_valid_reg;
    assign result.offset_time_ns = out_time_reg;
    assign result.point_status   = out_status_reg;

    lpato_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .x_in  (point.x_pos),
        .y_in  (point.y_pos),
        .res   (cres)
    );

    lpato_ram #(
        .WIDTH (RAM_W),
        .DEPTH (RINGS)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ring_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_ring),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (point.valid)
                begin
                    state_next = in_range ? S_AZIM : S_DONE;
                end
            end
            S_AZIM:
            begin
                if (cres.done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_FIX;
            end
            S_FIX:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        point.ready  = 1'b0;
        ram_we       = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            S_IDLE: point.ready = 1'b1;
            S_FIX:  ram_we      = 1'b1;
            S_DONE: out_load    = !out_valid_reg || result.ready;
            default:
            begin
            end
        endcase
        accept       = point.ready && point.valid;
        cordic_start = accept && in_range;
    end

    always_comb
    begin
        seen_next = seen_reg;
        if (accept && point.first_of_cloud)
        begin
            seen_next = '0;
        end
        if (accept && in_range)
        begin
            seen_next[in_ring] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seen_reg      <= '0;
            period_reg    <= PERIOD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            if (cfg.valid && cfg.ready)
            begin
                period_reg <= cfg.scan_period_ns;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_reg       <= in_ring;
            seen_hit_reg   <= in_range && !point.first_of_cloud && seen_reg[in_ring];
            res_time_reg   <= '0;
            res_status_reg <= ST_RANGE;
        end
        if (state_reg == S_AZIM && cres.done)
        begin
            angle_reg <= cres.angle;
            diff_reg  <= first_angle - cres.angle;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(diff_reg) * PROD_W'(period_reg);
        end
        if (state_reg == S_FIX)
        begin
            res_time_reg   <= seen_hit_reg ? t_fix : '0;
            res_status_reg <= seen_hit_reg ? ST_OK : ST_FIRST;
        end
        if (out_load)
        begin
            out_time_reg   <= res_time_reg;
            out_status_reg <= res_status_reg;
        end
    end

endmodule

>>> rtl/lpato_checker.sv
// port level checker for the point time block and its bind
`include "assert_macros.svh"

module lpato_checker import lpato_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [TIME_W-1:0]   offset_time_ns,
    input logic [STATUS_W-1:0] point_status
);

    // one point at a time
    `LPATO_ASSERT_RST(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready)

    // a new result appears as the block goes back to idle
    `LPATO_ASSERT_RST(a_result_at_idle, clk, rst_n, $rose(out_valid) |-> in_ready)

    // stalled result stays
    `LPATO_ASSERT_RST(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid)

    // time is zero unless it was computed
    `LPATO_ASSERT(a_time_zero, clk, (out_valid && point_status != ST_OK) |-> (offset_time_ns == '0))

endmodule

bind lidar_point_azimuth_time_offset lpato_checker u_lpato_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (point.valid),
    .in_ready       (point.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .offset_time_ns (result.offset_time_ns),
    .point_status   (result.point_status)
);
